// File: rtl/core/irpte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpte_pkg
// shared types and constants of the infrared pulse timing encoder
// ----------------------------------------------------------------------------
package irpte_pkg;

	localparam int IRPTE_MAX_BYTES = 16;

	localparam int DUR_W = 20;
	localparam int CFG_IDX_W = 3;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2
	} op_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CODING_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_MARK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_SPACE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MARK       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MARK      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE     = 3'd7;

	localparam logic [DUR_W-1:0] RST_SILENCE_TIME   = 20'd27000;
	localparam logic [DUR_W-1:0] RST_PREAMBLE_MARK  = 20'd9000;
	localparam logic [DUR_W-1:0] RST_PREAMBLE_SPACE = 20'd4500;
	localparam logic [DUR_W-1:0] RST_ONE_MARK       = 20'd560;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE      = 20'd1690;
	localparam logic [DUR_W-1:0] RST_ZERO_MARK      = 20'd560;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE     = 20'd560;

	// write port of the data byte store
	typedef struct packed {
		logic       en;
		logic [3:0] index;
		logic [7:0] value;
	} store_wr_t;

endpackage
`default_nettype wire

// File: rtl/core/irpte_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpte_store
// data byte store: synchronous memory with valid bits and write forwarding
// ----------------------------------------------------------------------------
module irpte_store #(
	parameter int MAX_BYTES = irpte_pkg::IRPTE_MAX_BYTES
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  irpte_pkg::store_wr_t wr,
	input  wire  [7:0]           rd_pos,
	output logic [7:0]           rd_byte
);
	import irpte_pkg::*;

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	logic [7:0]           mem_q [MAX_BYTES];
	logic [MAX_BYTES-1:0] valid_q;
	logic [7:0]           rd_data_q;
	logic [7:0]           fwd_data_q;
	logic                 fwd_q;
	logic                 rd_ok_q;

	logic [4:0]    wr_idx;
	logic [4:0]    rd_idx;
	logic          wr_hit;
	logic          rd_in;
	logic          fwd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_idx  = {1'b0, wr.index};
	assign wr_hit  = wr.en && ({1'b0, wr_idx} < 6'(MAX_BYTES));
	assign wr_addr = wr_idx[AW-1:0];
	assign rd_idx  = rd_pos[7:3];
	assign rd_in   = {1'b0, rd_idx} < 6'(MAX_BYTES);
	assign rd_addr = rd_in ? rd_idx[AW-1:0] : '0;
	// a write in the same cycle as the read of that byte wins
	assign fwd     = wr_hit && rd_in && (wr_idx == rd_idx);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem_q[wr_addr] <= wr.value;
		end
		rd_data_q  <= mem_q[rd_addr];
		fwd_data_q <= wr.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_q   <= 1'b0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				valid_q[wr_addr] <= 1'b1;
			end
			fwd_q   <= fwd;
			rd_ok_q <= rd_in && (valid_q[rd_addr] || fwd);
		end
	end

	// bytes never written and positions past the store read as zero
	assign rd_byte = !rd_ok_q ? 8'd0 : (fwd_q ? fwd_data_q : rd_data_q);

endmodule
`default_nettype wire

// File: rtl/core/ir_pulse_timing_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_timing_encoder
// infrared transmit timing generator: silence, preamble, coded data bits
// ----------------------------------------------------------------------------
// One request is taken per cycle while the output side keeps up. A request
// passes through the processing stage and its level/duration result is
// then shown from the output register. Byte writes and frame starts give no
// result. The byte that holds the next data bit is read from the store ahead
// of its use, addressed by the bit counter's next value, so back-to-back step
// requests never wait on the memory; the output register is the only place
// that stalls.
// The store reads as zeros after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module ir_pulse_timing_encoder #(
	parameter int MAX_BYTES = irpte_pkg::IRPTE_MAX_BYTES
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [irpte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [irpte_pkg::DUR_W-1:0]     cfg_data,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	input  wire  [23:0]                     s_axis_tdata,  // byte_index, byte_value, bit_count
	input  wire  [1:0]                      s_axis_tuser,  // op
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // duration, level
	output logic                            m_axis_tlast
);
	import irpte_pkg::*;

	typedef enum logic [1:0] {
		PH_SILENCE  = 2'd0,
		PH_PREAMBLE = 2'd1,
		PH_ENCODE   = 2'd2
	} phase_t;

	// configuration
	logic             coding_mode_q;
	logic [DUR_W-1:0] silence_time_q;
	logic [DUR_W-1:0] preamble_mark_q;
	logic [DUR_W-1:0] preamble_space_q;
	logic [DUR_W-1:0] one_mark_q;
	logic [DUR_W-1:0] one_space_q;
	logic [DUR_W-1:0] zero_mark_q;
	logic [DUR_W-1:0] zero_space_q;

	// processing stage
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [3:0] byte_index_s1;
	logic [7:0] byte_value_s1;
	logic [7:0] bit_count_s1;

	// frame state
	phase_t     phase_q;
	logic [8:0] tidx_q;
	logic [7:0] bits_q;
	logic [7:0] flen_q;

	// output register
	logic             out_valid_q;
	logic [DUR_W-1:0] out_dur_q;
	logic             out_lvl_q;
	logic             out_done_q;

	phase_t           phase_d;
	logic [8:0]       tidx_d;
	logic [7:0]       bits_d;
	logic [7:0]       flen_d;
	logic [DUR_W-1:0] dur;
	logic             lvl;
	logic             done;
	logic [7:0]       bits_inc;
	logic             cur_bit;
	logic             odd;
	logic             pwm;
	logic             man_lvl;

	logic      out_free;
	logic      fire_s1;
	logic      is_step;
	logic [7:0] rd_byte;
	store_wr_t st_wr;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign is_step       = (op_s1 == OP_STEP);
	assign fire_s1       = valid_s1 && (!is_step || out_free);
	assign s_axis_tready = !valid_s1 || fire_s1;

	assign st_wr.en    = fire_s1 && (op_s1 == OP_WRITE);
	assign st_wr.index = byte_index_s1;
	assign st_wr.value = byte_value_s1;

	irpte_store #(
		.MAX_BYTES(MAX_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (st_wr),
		.rd_pos (bits_d),
		.rd_byte(rd_byte)
	);

	assign cur_bit  = rd_byte[bits_q[2:0]];
	assign odd      = tidx_q[0];
	assign pwm      = (one_space_q == zero_space_q);
	assign man_lvl  = !odd ^ cur_bit;
	assign bits_inc = bits_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		tidx_d  = tidx_q;
		bits_d  = bits_q;
		flen_d  = flen_q;
		dur     = '0;
		lvl     = 1'b0;
		done    = 1'b0;
		if (fire_s1) begin
			case (op_s1)
				OP_START: begin
					flen_d  = bit_count_s1;
					tidx_d  = 9'd0;
					bits_d  = 8'd0;
					phase_d = PH_SILENCE;
				end
				OP_STEP: begin
					tidx_d = tidx_q + 9'd1;
					if (phase_q == PH_SILENCE) begin
						dur     = silence_time_q;
						phase_d = PH_PREAMBLE;
					end else if (phase_q == PH_PREAMBLE && preamble_mark_q != '0) begin
						if (tidx_q == 9'd1) begin
							dur = preamble_mark_q;
							lvl = 1'b1;
						end else begin
							dur     = preamble_space_q;
							phase_d = PH_ENCODE;
						end
					end else begin
						phase_d = PH_ENCODE;
						if (coding_mode_q) begin
							lvl = man_lvl;
							dur = one_mark_q;
							// the opening half of the last bit counts it when it is a mark
							if (!odd || (man_lvl && bits_inc == flen_q)) begin
								bits_d = bits_inc;
							end
						end else if (odd) begin
							dur = cur_bit ? one_mark_q : zero_mark_q;
							lvl = 1'b1;
							if (pwm) begin
								bits_d = bits_inc;
							end
						end else begin
							dur = cur_bit ? one_space_q : zero_space_q;
							if (!pwm) begin
								bits_d = bits_inc;
							end
						end
						done = (bits_d == flen_q) && lvl;
						if (done) begin
							tidx_d  = 9'd0;
							bits_d  = 8'd0;
							phase_d = PH_SILENCE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coding_mode_q    <= 1'b0;
			silence_time_q   <= RST_SILENCE_TIME;
			preamble_mark_q  <= RST_PREAMBLE_MARK;
			preamble_space_q <= RST_PREAMBLE_SPACE;
			one_mark_q       <= RST_ONE_MARK;
			one_space_q      <= RST_ONE_SPACE;
			zero_mark_q      <= RST_ZERO_MARK;
			zero_space_q     <= RST_ZERO_SPACE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODING_MODE:    coding_mode_q    <= cfg_data[0];
				CFG_SILENCE_TIME:   silence_time_q   <= cfg_data;
				CFG_PREAMBLE_MARK:  preamble_mark_q  <= cfg_data;
				CFG_PREAMBLE_SPACE: preamble_space_q <= cfg_data;
				CFG_ONE_MARK:       one_mark_q       <= cfg_data;
				CFG_ONE_SPACE:      one_space_q      <= cfg_data;
				CFG_ZERO_MARK:      zero_mark_q      <= cfg_data;
				CFG_ZERO_SPACE:     zero_space_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_SILENCE;
			tidx_q      <= 9'd0;
			bits_q      <= 8'd0;
			flen_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			phase_q <= phase_d;
			tidx_q  <= tidx_d;
			bits_q  <= bits_d;
			flen_q  <= flen_d;
			if (fire_s1 && is_step) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1         <= s_axis_tuser;
			byte_index_s1 <= s_axis_tdata[3:0];
			byte_value_s1 <= s_axis_tdata[11:4];
			bit_count_s1  <= s_axis_tdata[19:12];
		end
		if (fire_s1 && is_step) begin
			out_dur_q  <= dur;
			out_lvl_q  <= lvl;
			out_done_q <= done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_lvl_q, out_dur_q};
	assign m_axis_tlast  = out_done_q;

endmodule
`default_nettype wire

// File: rtl/core/irpte_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irpte_checker
// port-level checks of the infrared pulse timing encoder
// ----------------------------------------------------------------------------
module irpte_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire  [1:0] s_axis_tuser,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata,
	input wire        m_axis_tlast
);
	import irpte_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// a frame ends only on a mark
	a_done_mark: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[20])
		else $error("frame end on a space");

	// with the output register empty the input side never stalls
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output empty");

	// a step request taken into an empty pipe reaches the output register
	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && s_axis_tvalid && s_axis_tready && !$past(s_axis_tvalid)
			&& s_axis_tuser == OP_STEP |=> ##1 m_axis_tvalid)
		else $error("step result missing");

endmodule

bind ir_pulse_timing_encoder irpte_checker u_irpte_checker (.*);
`default_nettype wire
